// ----- design/coinbase_script_length_splitter_assert.svh -----
// Assertion macros shared by the checker of the coinbase script length splitter.
// They expect a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef COINBASE_SCRIPT_LENGTH_SPLITTER_ASSERT_SVH
`define COINBASE_SCRIPT_LENGTH_SPLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSLS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("splitter check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define CSLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("splitter check failed in the following cycle");

`endif

// ----- design/csls_pkg.sv -----
// Shared types and constants of the coinbase script length splitter.
// No dependencies; every other file of the block but the assertion header imports this package.
`default_nettype none

package csls_pkg;

    typedef logic [7:0] t_byte;

    // Bytes of version, input count and previous output before the length.
    localparam logic [5:0] HEADER_LEN = 6'd41;

    localparam t_byte PFX_TWO  = 8'hfd;
    localparam t_byte PFX_FOUR = 8'hfe;
    localparam logic [31:0] MAX_TWO_BYTE = 32'h0000_ffff;

    localparam t_byte EXT_RESET = 8'd4;

    // Configuration register indexes.
    localparam logic CFG_EXT_ONE = 1'b0;
    localparam logic CFG_EXT_TWO = 1'b1;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_PREFIX = 6'b000010,
        PH_LENGTH = 6'b000100,
        PH_SCRIPT = 6'b001000,
        PH_TAIL   = 6'b010000,
        PH_DRAIN  = 6'b100000
    } t_phase;

    // All results caused by one input byte. Entry 0 goes out first; part_end
    // belongs to the last entry only.
    typedef struct packed {
        logic [2:0]      cnt;
        logic [4:0][7:0] bytes;
        logic            part;
        logic            pend;
        logic            fault;
    } t_bundle;

endpackage

`default_nettype wire

// ----- design/csls_in_if.sv -----
// Input byte channel of the coinbase script length splitter.
// Depends on csls_pkg for the byte type.
`default_nettype none

interface csls_in_if import csls_pkg::*;;
    logic  valid;
    logic  ready;
    t_byte in_byte;
    logic  in_final;

    modport source (output valid, output in_byte, output in_final, input ready);
    modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

`default_nettype wire

// ----- design/csls_out_if.sv -----
// Result channel of the coinbase script length splitter.
// Depends on csls_pkg for the byte type.
`default_nettype none

interface csls_out_if import csls_pkg::*;;
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  out_part;
    logic  part_end;
    logic  run_end;
    logic  fault;

    modport source (output valid, output out_byte, output out_part, output part_end,
                     output run_end, output fault, input ready);
    modport sink   (input valid, input out_byte, input out_part, input part_end,
                     input run_end, input fault, output ready);
endinterface

`default_nettype wire

// ----- design/coinbase_script_length_splitter.sv -----
// Top level of the coinbase script length splitter: channels, configuration
// and the result register. Depends on csls_pkg, csls_in_if, csls_out_if, csls_walk.
`default_nettype none

// Channel   Direction  Transaction carries
// i_in      sink       in_byte, in_final: one byte of a serialized coinbase
// o_out     source     out_byte, out_part, part_end, run_end, fault
// i_cfg_*   write      i_cfg_idx selects extranonce one (0) or two (1) size
//
// Each accepted byte is parsed in the cycle it is accepted and all of its
// results land in the result register at the following clock edge.
// A byte with at most one result frees the input as that result is taken, so
// the block moves one byte per cycle while the output is ready. A byte that
// completes the script length gives up to five results, sent from the result
// register one per cycle while the output is ready; the input is held only
// until the last of them is taken. Reset is synchronous and active low and
// restores the header phase and both extranonce sizes to four; no clearing pass.

module coinbase_script_length_splitter import csls_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    csls_in_if.sink    i_in,
    csls_out_if.source o_out,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_idx,
    input  wire t_byte i_cfg_data
);

    // Extranonce sizes; the user must write them only while the block is idle, the block does not enforce it.
    t_byte r_ext_one;
    t_byte r_ext_two;

    // Result register. r_left counts the results still to be sent; the
    // current one always sits in entry 0 and the rest shift down as each
    // transaction on the output completes.
    logic [2:0]      r_left;
    logic [4:0][7:0] r_bytes;
    logic            r_part;
    logic            r_pend;
    logic            r_fault;

    t_bundle w_bundle;
    logic    w_pop;
    logic    w_last;
    logic    w_accept;

    assign w_pop    = o_out.valid && o_out.ready;
    assign w_last   = (r_left == 3'd1);
    // A new byte may enter while the final result of the previous one leaves.
    assign i_in.ready = (r_left == 3'd0) || (w_pop && w_last);
    assign w_accept = i_in.valid && i_in.ready;

    csls_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_accept),
        .i_byte    (i_in.in_byte),
        .i_final   (i_in.in_final),
        .i_ext_one (r_ext_one),
        .i_ext_two (r_ext_two),
        .o_bundle  (w_bundle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_one <= EXT_RESET;
            r_ext_two <= EXT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EXT_ONE: r_ext_one <= i_cfg_data;
                CFG_EXT_TWO: r_ext_two <= i_cfg_data;
                default:     r_ext_one <= r_ext_one;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (w_accept) begin
            r_left <= w_bundle.cnt;
        end else if (w_pop) begin
            r_left <= r_left - 3'd1;
        end
    end

    // Payload needs no reset; it is only shown while r_left is nonzero.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bytes <= w_bundle.bytes;
            r_part  <= w_bundle.part;
            r_pend  <= w_bundle.pend;
            r_fault <= w_bundle.fault;
        end else if (w_pop) begin
            r_bytes <= {8'h00, r_bytes[4:1]};
        end
    end

    assign o_out.valid    = (r_left != 3'd0);
    assign o_out.out_byte = r_bytes[0];
    assign o_out.out_part = r_part;
    assign o_out.part_end = r_pend && w_last;
    assign o_out.run_end  = w_last;
    assign o_out.fault    = r_fault;

endmodule

`default_nettype wire

// ----- design/csls_walk.sv -----
// Transaction walker: parse state and the per-byte result bundle.
// Depends on csls_pkg.
`default_nettype none

module csls_walk import csls_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_adv,
    input  wire t_byte   i_byte,
    input  wire logic    i_final,
    input  wire t_byte   i_ext_one,
    input  wire t_byte   i_ext_two,
    output t_bundle      o_bundle
);

    t_phase      r_phase,  n_phase;
    logic [5:0]  r_pos,    n_pos;
    logic        r_short,  n_short;
    logic [1:0]  r_lidx,   n_lidx;
    logic [31:0] r_gather, n_gather;
    logic [31:0] r_script, n_script;

    logic [31:0] w_gather;
    logic        w_len_done;
    logic [31:0] w_orig;
    logic [32:0] w_sum;
    logic [31:0] w_val;
    logic        w_pe;
    t_bundle     w_emit;
    t_bundle     w_fault;
    t_bundle     w_bun;
    logic        w_clear;

    assign w_gather   = r_gather | ({24'd0, i_byte} << {r_lidx, 3'b000});
    assign w_len_done = (r_short && (r_lidx == 2'd1)) || (r_lidx == 2'd3);
    assign w_orig     = (r_phase == PH_PREFIX) ? {24'd0, i_byte} : w_gather;
    assign w_sum      = {1'b0, w_orig} + {25'd0, i_ext_one} + {25'd0, i_ext_two};
    assign w_val      = w_sum[31:0];
    assign w_pe       = (w_orig == 32'd0);

    always_comb begin
        w_fault       = '0;
        w_fault.cnt   = 3'd1;
        w_fault.fault = 1'b1;

        w_emit = '0;
        if (w_sum[32]) begin
            w_emit = w_fault;
        end else if (w_val < {24'd0, PFX_TWO}) begin
            w_emit.cnt      = 3'd1;
            w_emit.bytes[0] = w_val[7:0];
            w_emit.pend     = w_pe;
        end else if (w_val <= MAX_TWO_BYTE) begin
            w_emit.cnt      = 3'd3;
            w_emit.bytes[0] = PFX_TWO;
            w_emit.bytes[1] = w_val[7:0];
            w_emit.bytes[2] = w_val[15:8];
            w_emit.pend     = w_pe;
        end else begin
            w_emit.cnt      = 3'd5;
            w_emit.bytes[0] = PFX_FOUR;
            w_emit.bytes[1] = w_val[7:0];
            w_emit.bytes[2] = w_val[15:8];
            w_emit.bytes[3] = w_val[23:16];
            w_emit.bytes[4] = w_val[31:24];
            w_emit.pend     = w_pe;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_short  = r_short;
        n_lidx   = r_lidx;
        n_gather = r_gather;
        n_script = r_script;
        w_bun    = '0;
        w_clear  = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                if (i_final) begin
                    w_bun   = w_fault;
                    w_clear = 1'b1;
                end else begin
                    w_bun.cnt      = 3'd1;
                    w_bun.bytes[0] = i_byte;
                    n_pos          = r_pos + 6'd1;
                    if (n_pos >= HEADER_LEN) begin
                        n_phase = PH_PREFIX;
                    end
                end
            end
            PH_PREFIX, PH_LENGTH: begin
                if ((r_phase == PH_PREFIX && i_byte < PFX_TWO)
                        || (r_phase == PH_LENGTH && w_len_done)) begin
                    // The length is complete: emit the rewritten varint.
                    w_bun = w_emit;
                    if (i_final) begin
                        w_clear = 1'b1;
                    end else if (w_sum[32]) begin
                        n_phase = PH_DRAIN;
                    end else if (w_pe) begin
                        n_phase = PH_TAIL;
                    end else begin
                        n_phase  = PH_SCRIPT;
                        n_script = w_orig;
                    end
                end else if (i_final) begin
                    w_bun   = w_fault;
                    w_clear = 1'b1;
                end else if (r_phase == PH_PREFIX) begin
                    n_short  = (i_byte == PFX_TWO);
                    n_lidx   = 2'd0;
                    n_gather = 32'd0;
                    n_phase  = PH_LENGTH;
                end else begin
                    n_gather = w_gather;
                    n_lidx   = r_lidx + 2'd1;
                end
            end
            PH_SCRIPT: begin
                if (r_script[31:1] == 31'd0) begin
                    w_bun.cnt      = 3'd1;
                    w_bun.bytes[0] = i_byte;
                    w_bun.pend     = 1'b1;
                    n_script       = 32'd0;
                    if (i_final) begin
                        w_clear = 1'b1;
                    end else begin
                        n_phase = PH_TAIL;
                    end
                end else if (i_final) begin
                    w_bun   = w_fault;
                    w_clear = 1'b1;
                end else begin
                    w_bun.cnt      = 3'd1;
                    w_bun.bytes[0] = i_byte;
                    n_script       = r_script - 32'd1;
                end
            end
            PH_TAIL: begin
                w_bun.cnt      = 3'd1;
                w_bun.bytes[0] = i_byte;
                w_bun.part     = 1'b1;
                w_bun.pend     = i_final;
                w_clear        = i_final;
            end
            PH_DRAIN: begin
                w_clear = i_final;
            end
            default: begin
                w_clear = 1'b1;
            end
        endcase

        if (w_clear) begin
            n_phase  = PH_HEADER;
            n_pos    = 6'd0;
            n_short  = 1'b0;
            n_lidx   = 2'd0;
            n_gather = 32'd0;
            n_script = 32'd0;
        end
    end

    assign o_bundle = w_bun;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= 6'd0;
            r_short  <= 1'b0;
            r_lidx   <= 2'd0;
            r_gather <= 32'd0;
            r_script <= 32'd0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_short  <= n_short;
            r_lidx   <= n_lidx;
            r_gather <= n_gather;
            r_script <= n_script;
        end
    end

endmodule

`default_nettype wire

// ----- design/csls_checker.sv -----
// Port-level checker for the coinbase script length splitter, bound to the top.
// Depends on coinbase_script_length_splitter_assert.svh and csls_pkg.
`default_nettype none

`include "coinbase_script_length_splitter_assert.svh"

module csls_checker import csls_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_in_valid,
    input wire logic  i_in_ready,
    input wire logic  i_out_valid,
    input wire logic  i_out_ready,
    input wire t_byte i_out_byte,
    input wire logic  i_out_part,
    input wire logic  i_out_part_end,
    input wire logic  i_out_run_end,
    input wire logic  i_out_fault
);

    // A fault result stands alone and carries no byte.
    `CSLS_ASSERT_SAME(a_fault_alone, i_out_valid && i_out_fault,
        i_out_run_end && !i_out_part && !i_out_part_end && (i_out_byte == 8'h00))

    // Bytes of part two come one result per input byte.
    `CSLS_ASSERT_SAME(a_tail_single, i_out_valid && i_out_part, i_out_run_end)

    // No new byte enters while more results of the current one are pending.
    `CSLS_ASSERT_SAME(a_hold_input, i_out_valid && !i_out_run_end, !i_in_ready)

    // A stalled result keeps its byte.
    `CSLS_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_byte))

    // Only an empty result register or its last leaving result frees the input.
    `CSLS_ASSERT_SAME(a_ready_cause, i_in_ready && i_in_valid && i_out_valid,
        i_out_ready && i_out_run_end)

endmodule

bind coinbase_script_length_splitter csls_checker u_csls_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_byte     (o_out.out_byte),
    .i_out_part     (o_out.out_part),
    .i_out_part_end (o_out.part_end),
    .i_out_run_end  (o_out.run_end),
    .i_out_fault    (o_out.fault)
);

`default_nettype wire

// ----- test/coinbase_script_length_splitter_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for coinbase_script_length_splitter: streams serialized coinbase
// bytes, predicts each result byte and compares the result channel field by field.
// Depends on csls_pkg, csls_in_if, csls_out_if and the block itself.

module coinbase_script_length_splitter_test;
    import csls_pkg::*;

    // Idle cycles allowed after the last expected result, so that bytes which give no
    // result (length bytes, drained bytes) are surely through the block.
    localparam int SETTLE_CYCLES = 8;
    // Largest script that is sent in full; longer declared scripts are cut short.
    localparam int SCRIPT_MAX = 12;
    // Random coinbase bytes per configuration setting; about one message each.
    localparam int PHASE_BYTES = 40;
    // A 0xff prefix is read like 0xfe.
    localparam t_byte PFX_FOUR_ALT = 8'hff;

    typedef struct packed {
        t_byte data;
        logic  fin;
    } t_in_byte;

    typedef struct packed {
        t_byte data;
        logic  part;
        logic  pend;
        logic  last;
        logic  fault;
    } t_out_byte;

    // Encodings of the incoming script length.
    typedef enum int { LEN_ONE, LEN_FD, LEN_FE, LEN_FF } t_len_form;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  cfg_we;
    logic  cfg_idx;
    t_byte cfg_data;

    csls_in_if  in_if ();
    csls_out_if out_if ();

    coinbase_script_length_splitter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Our own copy of the parser state and the two extranonce sizes.
    t_phase      walk_phase;
    logic [5:0]  walk_pos;
    t_byte       walk_prefix;
    logic [31:0] walk_len;
    logic [2:0]  walk_len_left;
    logic [31:0] walk_script_left;
    t_byte       ext_one_bytes;
    t_byte       ext_two_bytes;

    t_in_byte    tx_bytes[$];       // bytes waiting to be offered on the input channel
    t_out_byte   emitted_bytes[$];  // predicted result bytes, oldest first
    t_byte       coinbase[$];       // coinbase message under construction
    int unsigned bytes_queued;
    int unsigned bytes_taken;
    bit          send_gaps;
    bit          recv_stalls;
    bit          failed;
    int unsigned gap_left;
    int unsigned stall_left;
    t_in_byte    head;
    t_out_byte   want;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void add_result(t_byte b, logic part, logic pend, logic flt);
        t_out_byte r;
        r.data  = b;
        r.part  = part;
        r.pend  = pend;
        r.last  = 1'b0;
        r.fault = flt;
        emitted_bytes = {emitted_bytes, r};
    endfunction

    function automatic void restart_walk();
        walk_phase       = PH_HEADER;
        walk_pos         = '0;
        walk_prefix      = '0;
        walk_len         = '0;
        walk_len_left    = '0;
        walk_script_left = '0;
    endfunction

    // Rewrites the script length with both extranonce sizes added, in minimal form.
    function automatic void emit_varint(logic [31:0] orig, logic fin);
        logic [32:0] total;
        logic [31:0] v;
        logic        pe;
        total = 33'(orig) + 33'(ext_one_bytes) + 33'(ext_two_bytes);
        v     = total[31:0];
        pe    = (orig == 32'd0);
        if (total[32]) begin
            // The new length does not fit: one fault, then drop bytes until the end.
            add_result(8'h00, 1'b0, 1'b0, 1'b1);
            if (fin) begin
                restart_walk();
            end else begin
                walk_phase = PH_DRAIN;
            end
        end else begin
            if (v < 32'(PFX_TWO)) begin
                add_result(v[7:0], 1'b0, pe, 1'b0);
            end else if (v <= MAX_TWO_BYTE) begin
                add_result(PFX_TWO, 1'b0, 1'b0, 1'b0);
                add_result(v[7:0], 1'b0, 1'b0, 1'b0);
                add_result(v[15:8], 1'b0, pe, 1'b0);
            end else begin
                add_result(PFX_FOUR, 1'b0, 1'b0, 1'b0);
                add_result(v[7:0], 1'b0, 1'b0, 1'b0);
                add_result(v[15:8], 1'b0, 1'b0, 1'b0);
                add_result(v[23:16], 1'b0, 1'b0, 1'b0);
                add_result(v[31:24], 1'b0, pe, 1'b0);
            end
            if (fin) begin
                restart_walk();
            end else if (orig == 32'd0) begin
                walk_phase = PH_TAIL;
            end else begin
                walk_phase       = PH_SCRIPT;
                walk_script_left = orig;
            end
        end
    endfunction

    // Advances the parser by one accepted byte and queues the result bytes it causes.
    function automatic void parse_coinbase_byte(t_byte b, logic fin);
        int         prior_count;
        logic [2:0] len_total;
        logic [1:0] len_idx;
        prior_count = emitted_bytes.size();
        case (walk_phase)
            PH_HEADER: begin
                if (fin) begin
                    add_result(8'h00, 1'b0, 1'b0, 1'b1);
                    restart_walk();
                end else begin
                    add_result(b, 1'b0, 1'b0, 1'b0);
                    walk_pos = walk_pos + 6'd1;
                    if (walk_pos >= HEADER_LEN) walk_phase = PH_PREFIX;
                end
            end
            PH_PREFIX: begin
                if (b < PFX_TWO) begin
                    emit_varint(32'(b), fin);
                end else if (fin) begin
                    add_result(8'h00, 1'b0, 1'b0, 1'b1);
                    restart_walk();
                end else begin
                    walk_prefix   = b;
                    walk_len      = '0;
                    walk_len_left = (b == PFX_TWO) ? 3'd2 : 3'd4;
                    walk_phase    = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                // Length bytes arrive little-endian.
                len_total     = (walk_prefix == PFX_TWO) ? 3'd2 : 3'd4;
                len_idx       = 2'(len_total - walk_len_left);
                walk_len      = walk_len | (32'(b) << (8 * len_idx));
                walk_len_left = walk_len_left - 3'd1;
                if (walk_len_left == 3'd0 || walk_len_left > len_total) begin
                    emit_varint(walk_len, fin);
                end else if (fin) begin
                    add_result(8'h00, 1'b0, 1'b0, 1'b1);
                    restart_walk();
                end
            end
            PH_SCRIPT: begin
                if (walk_script_left <= 32'd1) begin
                    add_result(b, 1'b0, 1'b1, 1'b0);
                    walk_script_left = '0;
                    if (fin) begin
                        restart_walk();
                    end else begin
                        walk_phase = PH_TAIL;
                    end
                end else if (fin) begin
                    add_result(8'h00, 1'b0, 1'b0, 1'b1);
                    restart_walk();
                end else begin
                    add_result(b, 1'b0, 1'b0, 1'b0);
                    walk_script_left = walk_script_left - 32'd1;
                end
            end
            PH_TAIL: begin
                add_result(b, 1'b1, fin, 1'b0);
                if (fin) restart_walk();
            end
            default: begin
                // Draining after an overflow: nothing comes out.
                if (fin) restart_walk();
            end
        endcase
        if (emitted_bytes.size() > prior_count) begin
            emitted_bytes[emitted_bytes.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    // Idle length: mostly none, some short, a few long.
    function automatic int unsigned draw_gap(bit enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Appends one byte to the message under construction.
    function automatic void put_coinbase(t_byte b);
        coinbase = {coinbase, b};
    endfunction

    function automatic void add_random(int count);
        for (int k = 0; k < count; k++) put_coinbase(t_byte'($urandom_range(0, 255)));
    endfunction

    function automatic void add_header(bit extremes);
        for (int k = 0; k < int'(HEADER_LEN); k++) begin
            if (extremes) begin
                put_coinbase((k % 2) ? 8'hff : 8'h00);
            end else begin
                put_coinbase(t_byte'($urandom_range(0, 255)));
            end
        end
    endfunction

    function automatic void add_varint(t_len_form form, logic [31:0] len);
        case (form)
            LEN_ONE: put_coinbase(len[7:0]);
            LEN_FD: begin
                put_coinbase(PFX_TWO);
                put_coinbase(len[7:0]);
                put_coinbase(len[15:8]);
            end
            default: begin
                put_coinbase((form == LEN_FE) ? PFX_FOUR : PFX_FOUR_ALT);
                put_coinbase(len[7:0]);
                put_coinbase(len[15:8]);
                put_coinbase(len[23:16]);
                put_coinbase(len[31:24]);
            end
        endcase
    endfunction

    // Hands the message to the driver. A cut position ends it early with the final
    // flag on that byte; a negative cut keeps the whole message.
    function automatic void send_coinbase(int cut);
        int       stop;
        t_in_byte item;
        stop = (cut < 0 || cut >= coinbase.size()) ? coinbase.size() - 1 : cut;
        for (int k = 0; k <= stop; k++) begin
            item.data = coinbase[k];
            item.fin  = (k == stop);
            tx_bytes = {tx_bytes, item};
            bytes_queued++;
        end
        coinbase.delete();
    endfunction

    // Header, script length and body bytes (script plus whatever follows).
    function automatic void queue_coinbase(t_len_form form, logic [31:0] len, int body,
                                           int cut);
        add_header(1'b0);
        add_varint(form, len);
        add_random(body);
        send_coinbase(cut);
    endfunction

    // One random message; returns its byte count for the budget, less its length bytes.
    function automatic int queue_random_coinbase();
        int          pick;
        int          ext_sum;
        int          script;
        int          tail;
        int          cut;
        int          counted;
        logic [31:0] len;
        t_len_form   form;
        ext_sum = int'(ext_one_bytes) + int'(ext_two_bytes);
        pick    = $urandom_range(0, 99);
        if (pick < 8) begin
            // Junk that usually ends inside the header.
            add_random($urandom_range(1, 50));
            counted = coinbase.size();
            send_coinbase(-1);
            return counted;
        end
        // Most lengths are short enough to send the whole script; the rest sit on the
        // boundaries of the output encodings, are drawn at random or push the sum past 32 bits.
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            len = $urandom_range(0, SCRIPT_MAX);
        end else if (pick < 65) begin
            len = (ext_sum > 252) ? 32'($urandom_range(0, 3))
                                  : 32'(252 - ext_sum + $urandom_range(0, 1));
        end else if (pick < 75) begin
            len = 32'(65535 - ext_sum + $urandom_range(0, 1));
        end else if (pick < 85) begin
            len = $urandom();
        end else begin
            len = 32'hffff_ffff - 32'(ext_sum) + 32'($urandom_range(0, 1));
        end
        pick = $urandom_range(0, 99);
        if (len < 32'(PFX_TWO) && pick < 55) begin
            form = LEN_ONE;
        end else if (len <= MAX_TWO_BYTE && pick < 75) begin
            form = LEN_FD;
        end else if (pick % 2) begin
            form = LEN_FE;
        end else begin
            form = LEN_FF;
        end
        script  = (len > SCRIPT_MAX) ? $urandom_range(0, SCRIPT_MAX) : int'(len);
        tail    = (script == len) ? $urandom_range(0, 6) : 0;
        counted = int'(HEADER_LEN) + script + tail;
        if ((33'(len) + 33'(ext_sum)) > 33'h0_ffff_ffff) counted = int'(HEADER_LEN);
        cut = ($urandom_range(0, 99) < 12)
            ? $urandom_range(0, int'(HEADER_LEN) + 4 + script + tail) : -1;
        queue_coinbase(form, len, script + tail, cut);
        return counted;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers queued bytes, predicts on every accepted transaction.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid    <= 1'b0;
            in_if.in_byte  <= '0;
            in_if.in_final <= 1'b0;
            gap_left = 0;
        end else begin
            // The byte on the channel is taken at this edge: the model sees it now,
            // and its results can show up no earlier than the next edge.
            if (in_if.valid && in_if.ready) begin
                parse_coinbase_byte(in_if.in_byte, in_if.in_final);
                bytes_taken++;
            end
            // A new byte goes out only when the channel is free; valid is written
            // once per edge so a held-high valid never glitches.
            if (!in_if.valid || in_if.ready) begin
                if (gap_left == 0 && tx_bytes.size() > 0) begin
                    head = tx_bytes.pop_front();
                    in_if.valid    <= 1'b1;
                    in_if.in_byte  <= head.data;
                    in_if.in_final <= head.fin;
                    gap_left = draw_gap(send_gaps);
                end else begin
                    in_if.valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each accepted transaction against the oldest prediction
    // and throttles ready at random.
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [7:0] expected,
                                        logic [7:0] actual);
        if (actual !== expected) begin
            $error("%s: expected %0h, got %0h", name, expected, actual);
            failed = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (emitted_bytes.size() == 0) begin
                    $error("result with no prediction waiting: out_byte %0h fault %0b",
                           out_if.out_byte, out_if.fault);
                    failed = 1'b1;
                end else begin
                    want = emitted_bytes.pop_front();
                    check_field("out_byte", want.data, out_if.out_byte);
                    check_field("out_part", want.part, out_if.out_part);
                    check_field("part_end", want.pend, out_if.part_end);
                    check_field("run_end", want.last, out_if.run_end);
                    check_field("fault", want.fault, out_if.fault);
                end
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                stall_left = draw_gap(recv_stalls);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    // Returns once every queued byte is taken and every predicted byte has arrived,
    // and after a settling wait for bytes that produce nothing.
    task automatic wait_idle();
        while (bytes_taken != bytes_queued || emitted_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Registers are only written while the block is idle, so the model's copy can be
    // updated right here.
    task automatic write_ext(logic idx, t_byte value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_EXT_ONE) begin
            ext_one_bytes = value;
        end else begin
            ext_two_bytes = value;
        end
    endtask

    initial begin
        int    budget;
        t_byte one_size;
        t_byte two_size;

        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_EXT_ONE;
        cfg_data       = '0;
        in_if.valid    = 1'b0;
        in_if.in_byte  = '0;
        in_if.in_final = 1'b0;
        out_if.ready   = 1'b0;
        bytes_queued   = 0;
        bytes_taken    = 0;
        failed         = 1'b0;
        send_gaps      = 1'b1;
        recv_stalls    = 1'b1;
        ext_one_bytes  = EXT_RESET;
        ext_two_bytes  = EXT_RESET;
        restart_walk();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed messages, run with the reset sizes (sum of eight).
        // The final flag on the very first byte.
        add_random(1);
        send_coinbase(-1);
        // Empty script followed by part two.
        queue_coinbase(LEN_ONE, 32'd0, 3, -1);
        // A non-minimal two-byte length whose new sum is exactly 0xfd, so the
        // three-byte form goes out; the message then ends early inside the script.
        queue_coinbase(LEN_FD, 32'h0000_00f5, 3, -1);
        // A 0xff prefix behaves like 0xfe; part one ends together with the message.
        queue_coinbase(LEN_FF, 32'd1, 1, -1);
        // Early end inside the length bytes.
        queue_coinbase(LEN_FE, 32'd9, 0, int'(HEADER_LEN) + 2);
        // A sum just above 0xffff takes the five-byte form; the script is cut short.
        queue_coinbase(LEN_FD, 32'h0000_fff8, 1, -1);
        // Length overflow: a fault, then the remaining bytes are dropped.
        queue_coinbase(LEN_FF, 32'hffff_fff8, 4, -1);

        // Random messages under several size settings, extremes first. Idling on each
        // side is switched per setting so some stretches run flat out.
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            case (p)
                0: begin one_size = 8'd0;   two_size = 8'd0;   end
                1: begin one_size = 8'd255; two_size = 8'd255; end
                2: begin one_size = 8'd255; two_size = 8'd0;   end
                3: begin one_size = 8'd0;   two_size = 8'd255; end
                default: begin
                    one_size = t_byte'($urandom_range(0, 255));
                    two_size = t_byte'($urandom_range(0, 255));
                end
            endcase
            write_ext(CFG_EXT_ONE, one_size);
            write_ext(CFG_EXT_TWO, two_size);
            send_gaps   = (p % 4) != 2 && (p % 4) != 3;
            recv_stalls = (p % 4) != 1 && (p % 4) != 3;
            if (p >= 4) begin
                send_gaps   = 1'b1;
                recv_stalls = 1'b1;
            end
            budget = 0;
            while (budget < PHASE_BYTES) budget += queue_random_coinbase();
        end

        wait_idle();
        if (!failed) begin
            $display("coinbase_script_length_splitter test passed");
        end else begin
            $display("coinbase_script_length_splitter test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("coinbase_script_length_splitter test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/csls_pkg.sv
design/csls_in_if.sv
design/csls_out_if.sv
design/csls_walk.sv
design/coinbase_script_length_splitter.sv
design/csls_checker.sv
test/coinbase_script_length_splitter_test.sv
